>>> rtl/vlfr_pkg.sv
package vlfr_pkg;

	localparam int LENGTH_BITS  = 16;
	localparam int VARINT_BITS  = 32;
	localparam int GROUP_BITS   = 7;
	localparam int MAX_GROUPS   = 5;
	localparam int MORE_BIT     = 7;
	localparam int BYTE_BITS    = 8;
	localparam int CFG_BITS     = 16;
	localparam int GCOUNT_BITS  = 3;
	localparam int SHIFT_BITS   = 6;

	localparam logic [CFG_BITS-1:0] MAX_FRAME_LEN_RESET = CFG_BITS'(1024);

	typedef enum logic [1:0] {
		STATUS_PAYLOAD  = 2'd0,
		STATUS_OVERFLOW = 2'd1,
		STATUS_LENGTH   = 2'd2
	} status_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0]   payload_byte;
		logic [LENGTH_BITS-1:0] byte_index;
		logic [LENGTH_BITS-1:0] frame_length;
		logic                   last_of_frame;
		status_t                status;
	} result_t;

endpackage

>>> rtl/vlfr_in_stage.sv
module vlfr_in_stage
	import vlfr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BYTE_BITS-1:0] in_byte,
	input  logic                 advance,
	output logic                 valid_s1,
	output logic [BYTE_BITS-1:0] byte_s1
);

	logic valid_s1_r;

	// hold the byte while the next stage cannot take it
	assign in_stall = valid_s1_r && !advance;
	assign valid_s1 = valid_s1_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_r <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1_r <= 1'b1;
		end else if (advance) begin
			valid_s1_r <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

>>> rtl/vlfr_parse.sv
module vlfr_parse
	import vlfr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [BYTE_BITS-1:0] byte_s1,
	input  logic [CFG_BITS-1:0]  max_frame_len_q,
	output logic                 res_valid,
	output result_t              res
);

	logic                   in_payload_q;
	logic [GCOUNT_BITS-1:0] group_count_q;
	logic [VARINT_BITS-1:0] length_accum_q;
	logic [LENGTH_BITS-1:0] bytes_left_q;

	logic [SHIFT_BITS-1:0]  shift;
	logic [VARINT_BITS-1:0] new_accum;
	logic                   more;
	logic                   overflow;
	logic                   len_bad;
	logic                   last;
	logic [LENGTH_BITS-1:0] frame_len;

	assign shift     = SHIFT_BITS'(group_count_q) * SHIFT_BITS'(GROUP_BITS);
	assign new_accum = length_accum_q
		| (VARINT_BITS'(byte_s1[GROUP_BITS-1:0]) << shift);
	assign more      = byte_s1[MORE_BIT];
	assign overflow  = more && (group_count_q == GCOUNT_BITS'(MAX_GROUPS - 1));
	assign len_bad   = (new_accum == '0)
		|| (new_accum >= VARINT_BITS'(max_frame_len_q));
	assign frame_len = length_accum_q[LENGTH_BITS-1:0];
	assign last      = (bytes_left_q <= LENGTH_BITS'(1));

	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		if (in_payload_q) begin
			res_valid          = fire;
			res.payload_byte   = byte_s1;
			res.byte_index     = frame_len - bytes_left_q;
			res.frame_length   = frame_len;
			res.last_of_frame  = last;
			res.status         = STATUS_PAYLOAD;
		end else if (overflow) begin
			res_valid  = fire;
			res.status = STATUS_OVERFLOW;
		end else if (!more && len_bad) begin
			res_valid  = fire;
			res.status = STATUS_LENGTH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q   <= 1'b0;
			group_count_q  <= '0;
			length_accum_q <= '0;
			bytes_left_q   <= '0;
		end else if (fire) begin
			if (in_payload_q) begin
				if (last) begin
					in_payload_q   <= 1'b0;
					group_count_q  <= '0;
					length_accum_q <= '0;
					bytes_left_q   <= '0;
				end else begin
					bytes_left_q <= bytes_left_q - LENGTH_BITS'(1);
				end
			end else if (more) begin
				if (overflow) begin
					group_count_q  <= '0;
					length_accum_q <= '0;
				end else begin
					group_count_q  <= group_count_q + GCOUNT_BITS'(1);
					length_accum_q <= new_accum;
				end
			end else if (len_bad) begin
				group_count_q  <= '0;
				length_accum_q <= '0;
			end else begin
				// length is below the limit, so it fits the low bits
				in_payload_q   <= 1'b1;
				group_count_q  <= '0;
				length_accum_q <= new_accum;
				bytes_left_q   <= new_accum[LENGTH_BITS-1:0];
			end
		end
	end

endmodule

>>> rtl/vlfr_out_stage.sv
module vlfr_out_stage
	import vlfr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    res_valid,
	input  result_t res,
	input  logic    out_stall,
	output logic    out_valid,
	output logic    advance,
	output result_t res_q
);

	logic out_valid_q;

	// the register is free when empty or when its transfer completes now
	assign advance   = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

endmodule

>>> rtl/varint_length_frame_receiver_unit.sv
// Deframer for a byte stream of varint length-prefixed frames. Each frame is a
// little-endian base-128 length prefix (up to five groups) and then that many
// payload bytes; every payload byte comes out with its index, the frame length
// and a last flag, and a prefix that runs past five groups (status 1) or gives a
// length of zero or not below max_frame_len (status 2) yields one error result,
// after which a new prefix is expected. Prefix bytes give no result. One byte is
// taken every cycle unless the output stalls: each byte passes an input register,
// one step of prefix or payload logic, and a result register. A write to
// max_frame_len applies at the next length check.
module varint_length_frame_receiver_unit
	import vlfr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   max_frame_len_we,
	input  logic [CFG_BITS-1:0]    max_frame_len,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [BYTE_BITS-1:0]   in_byte,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [BYTE_BITS-1:0]   payload_byte,
	output logic [LENGTH_BITS-1:0] byte_index,
	output logic [LENGTH_BITS-1:0] frame_length,
	output logic                   last_of_frame,
	output logic [1:0]             status
);

	logic [CFG_BITS-1:0]  max_frame_len_q;
	logic                 advance;
	logic                 valid_s1;
	logic [BYTE_BITS-1:0] byte_s1;
	logic                 res_valid;
	result_t              res;
	result_t              res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_len_q <= MAX_FRAME_LEN_RESET;
		end else if (max_frame_len_we) begin
			max_frame_len_q <= max_frame_len;
		end
	end

	vlfr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	vlfr_parse u_parse (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (valid_s1 && advance),
		.byte_s1         (byte_s1),
		.max_frame_len_q (max_frame_len_q),
		.res_valid       (res_valid),
		.res             (res)
	);

	vlfr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.advance   (advance),
		.res_q     (res_q)
	);

	assign payload_byte  = res_q.payload_byte;
	assign byte_index    = res_q.byte_index;
	assign frame_length  = res_q.frame_length;
	assign last_of_frame = res_q.last_of_frame;
	assign status        = res_q.status;

endmodule

>>> test/varint_length_frame_receiver_unit_tb.sv
`timescale 1ns / 100ps

module varint_length_frame_receiver_unit_tb
	import vlfr_pkg::*;
();

	localparam int QUIET_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 200;
	localparam int MAX_WAIT     = 13;
	localparam int SHORT_LEN    = 24;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   max_frame_len_we = 1'b0;
	logic [CFG_BITS-1:0]    max_frame_len = MAX_FRAME_LEN_RESET;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [BYTE_BITS-1:0]   in_byte = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [BYTE_BITS-1:0]   payload_byte;
	logic [LENGTH_BITS-1:0] byte_index;
	logic [LENGTH_BITS-1:0] frame_length;
	logic                   last_of_frame;
	logic [1:0]             status;

	varint_length_frame_receiver_unit i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.max_frame_len_we (max_frame_len_we),
		.max_frame_len    (max_frame_len),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.in_byte          (in_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.payload_byte     (payload_byte),
		.byte_index       (byte_index),
		.frame_length     (frame_length),
		.last_of_frame    (last_of_frame),
		.status           (status)
	);

	// stream bytes waiting to be driven, deframed results waiting to come out
	logic [BYTE_BITS-1:0] stream_q[$];
	result_t              pending_results_q[$];

	// deframer state as predicted
	logic [CFG_BITS-1:0]    rx_limit = MAX_FRAME_LEN_RESET;
	logic                   rx_in_payload = 1'b0;
	logic [GCOUNT_BITS-1:0] rx_groups = '0;
	logic [VARINT_BITS-1:0] rx_accum = '0;
	logic [LENGTH_BITS-1:0] rx_left = '0;

	logic          in_taken = 1'b0;
	logic          out_taken = 1'b0;
	bit            in_idle_on = 1'b1;
	bit            out_idle_on = 1'b1;
	int            in_gap_left = 0;
	int            out_wait_left = 0;
	int            hold_left = 0;
	int            hold_requests = 0;
	int            hold_served = 0;
	int            quiet_cycles = 0;
	int            mismatches = 0;
	int            queued_bytes = 0;
	int            bytes_in = 0;
	int            payload_seen = 0;
	int            overflow_seen = 0;
	int            length_err_seen = 0;
	int            limit_writes = 0;
	logic [15:0]   stim_limit = MAX_FRAME_LEN_RESET;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int draw_wait(input bit idle_on);
		return idle_on ? int'($urandom_range(0, MAX_WAIT)) : 0;
	endfunction

	function automatic void restart_prefix();
		rx_in_payload = 1'b0;
		rx_groups = '0;
		rx_accum = '0;
		rx_left = '0;
	endfunction

	function automatic void deframe_byte(input logic [BYTE_BITS-1:0] b, output result_t r,
			output bit produced);
		logic [LENGTH_BITS-1:0] len;
		int                     shift;
		r = '0;
		produced = 1'b0;
		if (rx_in_payload) begin
			len = rx_accum[LENGTH_BITS-1:0];
			r.payload_byte = b;
			r.byte_index = len - rx_left;
			r.frame_length = len;
			r.last_of_frame = (rx_left <= 16'd1);
			r.status = STATUS_PAYLOAD;
			produced = 1'b1;
			if (r.last_of_frame)
				restart_prefix();
			else
				rx_left = rx_left - 16'd1;
		end else begin
			shift = int'(rx_groups) * GROUP_BITS;
			// groups beyond bit 31 are truncated by the 32-bit shift
			if (shift < VARINT_BITS)
				rx_accum = rx_accum | (VARINT_BITS'(b[GROUP_BITS-1:0]) << shift);
			if (b[MORE_BIT]) begin
				rx_groups = rx_groups + GCOUNT_BITS'(1);
				if (int'(rx_groups) * GROUP_BITS >= VARINT_BITS) begin
					restart_prefix();
					r.status = STATUS_OVERFLOW;
					produced = 1'b1;
				end
			end else if (rx_accum == '0 || rx_accum >= VARINT_BITS'(rx_limit)) begin
				restart_prefix();
				r.status = STATUS_LENGTH;
				produced = 1'b1;
			end else begin
				rx_in_payload = 1'b1;
				rx_groups = '0;
				rx_left = rx_accum[LENGTH_BITS-1:0];
			end
		end
	endfunction

	task automatic flag_field(input string name, input int unsigned want, input int unsigned got);
		mismatches++;
		$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
	endtask

	// sender: offer the next byte once the previous transfer is done and the gap has run out
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (in_gap_left != 0) begin
					in_valid <= 1'b0;
					in_gap_left <= in_gap_left - 1;
				end else if (stream_q.size() != 0) begin
					in_valid <= 1'b1;
					in_byte <= stream_q.pop_front();
					in_gap_left <= draw_wait(in_idle_on);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall for a random wait, possibly none, after each transfer, and hold off for a long stretch on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (out_taken)
				out_wait_left = draw_wait(out_idle_on);
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (out_wait_left != 0) begin
				out_wait_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		result_t want;
		bit      produced;
		in_taken <= in_valid && !in_stall;
		out_taken <= out_valid && !out_stall;
		if (arst_n) begin
			if (max_frame_len_we)
				rx_limit = max_frame_len;
			if (in_valid && !in_stall) begin
				bytes_in++;
				deframe_byte(in_byte, want, produced);
				if (produced)
					pending_results_q.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (pending_results_q.size() == 0) begin
					mismatches++;
					$display("%0t: result expected none, got byte %0d status %0d",
						$time, payload_byte, status);
				end else begin
					want = pending_results_q.pop_front();
					case (want.status)
						STATUS_PAYLOAD:  payload_seen++;
						STATUS_OVERFLOW: overflow_seen++;
						default:         length_err_seen++;
					endcase
					if (payload_byte !== want.payload_byte)
						flag_field("payload_byte", want.payload_byte, payload_byte);
					if (byte_index !== want.byte_index)
						flag_field("byte_index", want.byte_index, byte_index);
					if (frame_length !== want.frame_length)
						flag_field("frame_length", want.frame_length, frame_length);
					if (last_of_frame !== want.last_of_frame)
						flag_field("last_of_frame", want.last_of_frame, last_of_frame);
					if (status !== want.status)
						flag_field("status", want.status, status);
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("varint_length_frame_receiver_unit_tb: done, errors");
		$finish;
	end

	function automatic int min_groups(input logic [31:0] value);
		int n;
		n = 1;
		while (n < MAX_GROUPS && (value >> (GROUP_BITS * n)) != 0)
			n++;
		return n;
	endfunction

	task automatic queue_byte(input logic [BYTE_BITS-1:0] b);
		stream_q.push_back(b);
		queued_bytes++;
	endtask

	task automatic queue_prefix(input logic [31:0] value, input int groups);
		logic [BYTE_BITS-1:0] b;
		for (int k = 0; k < groups; k++) begin
			b = BYTE_BITS'(value >> (GROUP_BITS * k)) & 8'h7F;
			// fifth group: bits above 31 are junk and must be dropped
			if (k == MAX_GROUPS - 1)
				b[6:4] = 3'($urandom_range(0, 7));
			if (k != groups - 1)
				b[MORE_BIT] = 1'b1;
			queue_byte(b);
		end
	endtask

	task automatic queue_frame(input int len, input int groups);
		queue_prefix(32'(len), groups);
		repeat (len) queue_byte(BYTE_BITS'($urandom));
	endtask

	task automatic queue_random_unit();
		int          pick;
		int          max_len;
		int          len;
		int          groups;
		logic [31:0] bad;
		pick = $urandom_range(0, 99);
		max_len = (stim_limit > SHORT_LEN) ? SHORT_LEN : int'(stim_limit) - 1;
		if (pick < 70 && max_len >= 1) begin
			len = $urandom_range(1, max_len);
			groups = min_groups(len);
			if ($urandom_range(0, 3) == 0)
				groups = $urandom_range(groups, MAX_GROUPS);
			queue_frame(len, groups);
		end else if (pick < 85) begin
			case ($urandom_range(0, 2))
				0:       bad = '0;
				1:       bad = 32'(stim_limit) + $urandom_range(0, 3);
				default: bad = {16'($urandom_range(1, 16'hFFFF)), 16'($urandom_range(0, 3))};
			endcase
			groups = min_groups(bad);
			if ($urandom_range(0, 2) == 0)
				groups = $urandom_range(groups, MAX_GROUPS);
			queue_prefix(bad, groups);
		end else if (pick < 93) begin
			repeat (MAX_GROUPS) queue_byte(8'h80 | BYTE_BITS'($urandom_range(0, 127)));
		end else if (stim_limit <= 4096) begin
			// noise; keep it away from huge limits so it cannot open a giant frame
			repeat ($urandom_range(1, 3)) queue_byte(BYTE_BITS'($urandom));
		end
	endtask

	task automatic queue_random(input int n_bytes);
		int stop_at;
		stop_at = queued_bytes + n_bytes;
		while (queued_bytes < stop_at)
			queue_random_unit();
	endtask

	task automatic wait_drained();
		while (stream_q.size() != 0 || in_valid || pending_results_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] value);
		wait_drained();
		@(negedge clk);
		max_frame_len_we <= 1'b1;
		max_frame_len <= value;
		@(negedge clk);
		max_frame_len_we <= 1'b0;
		stim_limit = value;
		limit_writes++;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// one-byte frame, then a non-minimal two-group prefix with edge data
		queue_byte(8'h01); queue_byte(8'hFF);
		queue_byte(8'h83); queue_byte(8'h00);
		queue_byte(8'h00); queue_byte(8'h80); queue_byte(8'h7F);
		// zero length, plain and padded
		queue_byte(8'h00);
		queue_byte(8'h80); queue_byte(8'h00);
		// length equal to the reset limit
		queue_byte(8'h80); queue_byte(8'h08);
		// junk above bit 31 in the fifth group leaves a length of one
		queue_byte(8'h81); queue_byte(8'h80); queue_byte(8'h80); queue_byte(8'h80);
		queue_byte(8'h70); queue_byte(8'hA5);
		// five groups all continuing
		repeat (MAX_GROUPS) queue_byte(8'h80);
		// 0x10001 has small low bits but must fail the full-width compare
		queue_byte(8'h81); queue_byte(8'h80); queue_byte(8'h04);

		// change the limit between prefix and payload of an open frame
		queue_prefix(32'd5, 1);
		write_limit(16'd2);
		repeat (5) queue_byte(BYTE_BITS'($urandom));
		queue_random(80);

		write_limit(16'd0);
		queue_random(40);
		write_limit(16'd1);
		queue_random(40);

		// top limit, a five-group prefix and its frame streamed back to back
		write_limit(16'hFFFF);
		in_idle_on = 1'b0;
		out_idle_on = 1'b0;
		queue_frame(SHORT_LEN, MAX_GROUPS);
		wait_drained();
		in_idle_on = 1'b1;
		out_idle_on = 1'b1;
		queue_random(70);

		// hold the output while the input keeps streaming
		write_limit(MAX_FRAME_LEN_RESET);
		in_idle_on = 1'b0;
		hold_requests++;
		queue_frame(SHORT_LEN, 2);
		wait_drained();
		in_idle_on = 1'b1;
		queue_random(70);

		repeat (4) begin
			write_limit(16'($urandom_range(2, 3000)));
			in_idle_on = ($urandom_range(0, 3) != 0);
			out_idle_on = ($urandom_range(0, 3) != 0);
			queue_random(70);
		end

		wait_drained();
		$display("stream of %0d bytes over %0d limit settings", bytes_in, limit_writes);
		$display("results checked: %0d payload, %0d overflow, %0d length error",
			payload_seen, overflow_seen, length_err_seen);
		if (mismatches == 0)
			$display("varint_length_frame_receiver_unit_tb: done, clean");
		else
			$display("varint_length_frame_receiver_unit_tb: done, errors");
		$finish;
	end

endmodule

>>> varint_length_frame_receiver_unit.f
rtl/vlfr_pkg.sv
rtl/vlfr_in_stage.sv
rtl/vlfr_parse.sv
rtl/vlfr_out_stage.sv
rtl/varint_length_frame_receiver_unit.sv
test/varint_length_frame_receiver_unit_tb.sv
